[hw/rtl/mecs_pkg.sv]
// Shared types, constants and functions of the map exit code scrambler.
// Holds the generator step and the backup mixes; used by the byte unit and the top level.
package mecs_pkg;

  localparam int CodeBytes = 128;
  localparam int AddrW     = $clog2(CodeBytes);

  // Operation codes of a command word.
  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_EXIT = 2'd1,
    OP_READ = 2'd2,
    OP_NONE = 2'd3
  } op_e;

  // Round algorithms.
  typedef enum logic [2:0] {
    ALG_SHL_GEN = 3'd0,
    ALG_ADD_GEN = 3'd1,
    ALG_PAIR_L  = 3'd2,
    ALG_XOR_GEN = 3'd3,
    ALG_SUB_GEN = 3'd4,
    ALG_PAIR_R  = 3'd5,
    ALG_SHR_GEN = 3'd6,
    ALG_INVERT  = 3'd7
  } alg_e;

  // Control of the byte unit for one working byte.
  typedef struct packed {
    alg_e       alg;
    logic [7:0] gen;
    logic       carry;
    logic       odd;
  } alu_ctrl_t;

  localparam logic [7:0] GenK1   = 8'h89;
  localparam logic [7:0] GenK2   = 8'h2A;
  localparam logic [7:0] GenK3   = 8'h21;
  localparam logic [7:0] GenK4   = 8'h43;
  localparam logic [7:0] MapPre  = 8'h1B;
  localparam logic [7:0] MapOne  = 8'h06;
  localparam logic [7:0] MapTwo  = 8'h22;
  localparam logic [2:0] MixPre  = 3'd6;
  localparam logic [2:0] MixOne  = 3'd0;
  localparam logic [2:0] MixTwo  = 3'd4;

  // One generator step; state is {hi, lo}.
  function automatic logic [15:0] gen_step(input logic [15:0] g);
    logic [7:0] hi;
    logic [7:0] lo;
    logic [8:0] s;
    hi = g[15:8];
    lo = g[7:0] + hi;
    s  = {1'b0, hi} + {1'b0, GenK1};
    hi = s[7:0];
    s  = {1'b0, lo} + {1'b0, GenK2} + {8'd0, s[8]};
    lo = s[7:0];
    s  = {1'b0, hi} + {1'b0, GenK3} + {8'd0, s[8]};
    hi = s[7:0];
    s  = {1'b0, lo} + {1'b0, GenK4} + {8'd0, s[8]};
    lo = s[7:0];
    return {hi, lo};
  endfunction

  // Add chain from backup byte 3 down to byte 0.
  function automatic logic [31:0] chain_sum(input logic [31:0] b, input logic [7:0] start,
                                            input logic cin);
    logic [7:0] acc;
    logic       c;
    logic [8:0] s;
    logic [31:0] r;
    r   = b;
    acc = start;
    c   = cin;
    for (int i = 3; i >= 0; i--) begin
      s   = {1'b0, acc} + {1'b0, r[i*8 +: 8]} + {8'd0, c};
      c   = s[8];
      acc = s[7:0];
      r[i*8 +: 8] = acc;
    end
    return r;
  endfunction

  function automatic logic [31:0] mix_a(input logic [31:0] b, input logic [7:0] m);
    logic [8:0] t;
    logic [9:0] d;
    t = {1'b0, m ^ b[15:8]} + {1'b0, b[7:0]};
    d = {2'b0, t[7:0]} + 10'h100 - {2'b0, b[23:16]} - {9'd0, ~t[8]};
    return chain_sum(b, d[7:0], d[8]);
  endfunction

  function automatic logic [31:0] mix_rev(input logic [31:0] b, input logic [7:0] m);
    return {b[7:0] + m, b[15:8], b[23:16], b[31:24]};
  endfunction

  function automatic logic [31:0] mix_rot(input logic [31:0] b, input logic [7:0] m);
    logic [7:0] t;
    t = {m[6:0], 1'b0} ^ 8'hFF;
    t = t + b[7:0] - m;
    return {b[23:16], b[15:8], b[31:24], t};
  endfunction

  // One of the eight backup mixes.
  function automatic logic [31:0] backup_mix(input logic [31:0] b, input logic [2:0] n,
                                             input logic [7:0] m);
    logic [31:0] r;
    case (n)
      3'd0:    r = mix_a(b, m);
      3'd1:    r = chain_sum(b, m, 1'b1);
      3'd2:    r = mix_rev(b, m);
      3'd3:    r = chain_sum(mix_rev(b, m), m, 1'b1);
      3'd4:    r = mix_a(mix_rev(b, m), m);
      3'd5:    r = mix_rot(b, m);
      3'd6:    r = chain_sum(mix_rot(b, m), m, 1'b1);
      default: r = mix_a(mix_rot(b, m), m);
    endcase
    return r;
  endfunction

endpackage

[hw/rtl/mecs_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module mecs_ram #(
  parameter int Depth = 128,
  parameter int Width = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

[hw/rtl/mecs_byte_alu.sv]
// Byte unit: applies one round algorithm to one working byte.
// Depends on mecs_pkg.
module mecs_byte_alu (
  input  mecs_pkg::alu_ctrl_t ctrl_i,
  input  logic [7:0]          data_i,
  output logic [7:0]          data_o,
  output logic                carry_o
);
  import mecs_pkg::*;

  // Pair algorithms pass one bit from byte to byte in a carry register.
  always_comb begin
    data_o  = data_i;
    carry_o = ctrl_i.carry;
    case (ctrl_i.alg)
      ALG_SHL_GEN: data_o = {data_i[6:0], ctrl_i.gen[7]};
      ALG_ADD_GEN: data_o = data_i + ctrl_i.gen;
      ALG_PAIR_L: begin
        if (ctrl_i.odd) begin
          data_o  = {data_i[6:0], ctrl_i.carry};
          carry_o = data_i[7];
        end else begin
          data_o  = {ctrl_i.carry, data_i[7:1]};
          carry_o = data_i[0];
        end
      end
      ALG_XOR_GEN: data_o = data_i ^ ctrl_i.gen;
      ALG_SUB_GEN: data_o = data_i - ctrl_i.gen;
      ALG_PAIR_R: begin
        if (ctrl_i.odd) begin
          data_o  = {ctrl_i.carry, data_i[7:1]};
          carry_o = data_i[0];
        end else begin
          data_o  = {data_i[6:0], ctrl_i.carry};
          carry_o = data_i[7];
        end
      end
      ALG_SHR_GEN: data_o = {ctrl_i.gen[7], data_i[7:1]};
      default:     data_o = ~data_i;
    endcase
  end

endmodule

[hw/rtl/map_exit_code_scrambler_core.sv]
// Top level of the map exit code scrambler: sequencer, working code RAM, backup and generator.
// Depends on mecs_pkg, mecs_ram and mecs_byte_alu.
//
// A command word is taken when start_i is high and busy_o is low. op_i selects a load of
// start_value_i, a map exit for map_id_i, or a read of working byte byte_index_i.
// Each command gives one result word: result_valid_o is high for one cycle with data_byte_o
// (the byte read, zero otherwise) and backup_word_o (the backup after the command).
// The receiver cannot stall; results appear once and must be taken in that cycle.
// A load writes the working code one code byte per cycle. A map exit runs a pass of 16
// rounds, and for map 0x22 a second pass after one more backup mix. The pace is set by the
// single read port of the working code RAM: each round reads its selector byte, then
// sweeps all 128 bytes read-modify-write, one per cycle.
// Commands are taken one at a time; busy_o is high while a command is in work.
// Reset clears the backup, the generator and the sequencer; the working code is undefined
// until the first load.
module map_exit_code_scrambler_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [1:0]                  op_i,
  input  logic [63:0]                 start_value_i,
  input  logic [7:0]                  map_id_i,
  input  logic [mecs_pkg::AddrW-1:0]  byte_index_i,
  output logic                        result_valid_o,
  output logic [7:0]                  data_byte_o,
  output logic [31:0]                 backup_word_o
);
  import mecs_pkg::*;

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b00000000001,
    ST_LOAD  = 11'b00000000010,
    ST_READ  = 11'b00000000100,
    ST_MIXP  = 11'b00000001000,
    ST_MIXM  = 11'b00000010000,
    ST_SEL   = 11'b00000100000,
    ST_SELW  = 11'b00001000000,
    ST_SWEEP = 11'b00010000000,
    ST_DRAIN = 11'b00100000000,
    ST_MIX2  = 11'b01000000000,
    ST_DONE  = 11'b10000000000
  } state_e;

  state_e           state_q, state_d;
  logic [31:0]      backup_q, backup_d;
  logic [15:0]      gen_q, gen_d;
  logic [63:0]      win_q, win_d;
  logic [7:0]       map_q, map_d;
  logic [AddrW-1:0] cnt_q, cnt_d;
  logic [3:0]       round_q, round_d;
  logic             pass_q, pass_d;
  alg_e             alg_q, alg_d;
  logic             carry_q, carry_d;
  logic             pv_q, pv_d;
  logic [AddrW-1:0] paddr_q, paddr_d;
  logic             res_valid_q, res_valid_d;
  logic [7:0]       res_data_q, res_data_d;
  logic [31:0]      res_backup_q, res_backup_d;

  logic             accept;
  logic             ram_we;
  logic [AddrW-1:0] ram_waddr, ram_raddr, sweep_addr;
  logic [7:0]       ram_wdata, ram_rdata;
  logic [15:0]      gen_nx;
  logic [7:0]       gen_byte;
  logic [7:0]       sel_byte;
  logic [1:0]       bk_idx;
  logic [2:0]       main_mix;
  alu_ctrl_t        alu_ctrl;
  logic [7:0]       alu_data;
  logic             alu_carry;
  logic             uses_gen;

  assign accept   = start_i && !busy_o;
  assign busy_o   = (state_q != ST_IDLE);
  assign gen_nx   = gen_step(gen_q);
  assign gen_byte = gen_nx[15:8] ^ gen_nx[7:0];

  // Sweep goes down the code, except for the right shift, which goes up.
  assign sweep_addr = (alg_q == ALG_SHR_GEN) ? cnt_q : ~cnt_q;
  assign uses_gen   = (alg_q != ALG_PAIR_L) && (alg_q != ALG_PAIR_R) && (alg_q != ALG_INVERT);

  // Selector bit of round r is bit 15 - r of backup bytes 3..2.
  assign sel_byte = backup_q[16 + {1'b0, ~round_q}] ? {4'd0, ram_rdata[7:4]} : ram_rdata;

  assign bk_idx   = map_q[5:4];
  assign main_mix = (map_q == MapOne) ? MixOne : backup_q[{bk_idx, 3'd2} +: 3];

  // Byte unit on the word coming back from the RAM.
  always_comb begin
    alu_ctrl.alg   = alg_q;
    alu_ctrl.gen   = gen_byte;
    alu_ctrl.carry = carry_q;
    alu_ctrl.odd   = paddr_q[0];
  end

  mecs_byte_alu u_alu (
    .ctrl_i  (alu_ctrl),
    .data_i  (ram_rdata),
    .data_o  (alu_data),
    .carry_o (alu_carry)
  );

  mecs_ram #(
    .Depth (CodeBytes),
    .Width (8)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // RAM port selection.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = paddr_q;
    ram_wdata = alu_data;
    ram_raddr = byte_index_i;
    if (state_q == ST_LOAD) begin
      ram_we    = 1'b1;
      ram_waddr = cnt_q;
      ram_wdata = (cnt_q < AddrW'(8)) ? win_q[{cnt_q[2:0], 3'd0} +: 8] : win_q[7:0] + gen_byte;
    end else if (pv_q) begin
      ram_we = 1'b1;
    end
    if (state_q == ST_SEL) begin
      ram_raddr = AddrW'(round_q);
    end else if (state_q == ST_SWEEP) begin
      ram_raddr = sweep_addr;
    end
  end

  // Sequencer.
  always_comb begin
    state_d      = state_q;
    backup_d     = backup_q;
    gen_d        = gen_q;
    win_d        = win_q;
    map_d        = map_q;
    cnt_d        = cnt_q;
    round_d      = round_q;
    pass_d       = pass_q;
    alg_d        = alg_q;
    carry_d      = carry_q;
    pv_d         = 1'b0;
    paddr_d      = paddr_q;
    res_valid_d  = 1'b0;
    res_data_d   = res_data_q;
    res_backup_d = res_backup_q;

    // Write-back of the swept word.
    if (pv_q) begin
      carry_d = alu_carry;
      if (uses_gen) begin
        gen_d = gen_nx;
      end
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (op_i)
            OP_LOAD: begin
              win_d    = start_value_i;
              gen_d    = {start_value_i[7:0], start_value_i[15:8]};
              backup_d = start_value_i[31:0];
              cnt_d    = '0;
              state_d  = ST_LOAD;
            end
            OP_EXIT: begin
              map_d   = map_id_i;
              pass_d  = 1'b0;
              state_d = ST_MIXP;
            end
            OP_READ: state_d = ST_READ;
            default: begin
              res_valid_d  = 1'b1;
              res_data_d   = '0;
              res_backup_d = backup_q;
            end
          endcase
        end
      end
      ST_LOAD: begin
        if (cnt_q >= AddrW'(8)) begin
          gen_d = gen_nx;
          win_d = {win_q[7:0] + gen_byte, win_q[63:8]};
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == AddrW'(CodeBytes - 1)) begin
          state_d = ST_DONE;
        end
      end
      ST_READ: begin
        res_valid_d  = 1'b1;
        res_data_d   = ram_rdata;
        res_backup_d = backup_q;
        state_d      = ST_IDLE;
      end
      ST_MIXP: begin
        if (map_q == MapPre) begin
          backup_d = backup_mix(backup_q, MixPre, map_q);
        end
        state_d = ST_MIXM;
      end
      ST_MIXM: begin
        backup_d = backup_mix(backup_q, main_mix, map_q);
        round_d  = '0;
        state_d  = ST_SEL;
      end
      ST_SEL: begin
        if (round_q == 4'd0) begin
          gen_d = {backup_q[7:0], backup_q[15:8]};
        end
        state_d = ST_SELW;
      end
      ST_SELW: begin
        alg_d = alg_e'(sel_byte[3:1]);
        if (sel_byte[3:1] == ALG_PAIR_L || sel_byte[3:1] == ALG_PAIR_R) begin
          gen_d   = gen_nx;
          carry_d = gen_byte[7];
        end
        cnt_d   = '0;
        state_d = ST_SWEEP;
      end
      ST_SWEEP: begin
        pv_d    = 1'b1;
        paddr_d = sweep_addr;
        cnt_d   = cnt_q + 1'b1;
        if (cnt_q == AddrW'(CodeBytes - 1)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        round_d = round_q + 1'b1;
        if (round_q != 4'd15) begin
          state_d = ST_SEL;
        end else if (!pass_q && map_q == MapTwo) begin
          state_d = ST_MIX2;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_MIX2: begin
        backup_d = backup_mix(backup_q, MixTwo, map_q);
        pass_d   = 1'b1;
        round_d  = '0;
        state_d  = ST_SEL;
      end
      ST_DONE: begin
        res_valid_d  = 1'b1;
        res_data_d   = '0;
        res_backup_d = backup_q;
        state_d      = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      backup_q    <= '0;
      gen_q       <= '0;
      pv_q        <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      backup_q    <= backup_d;
      gen_q       <= gen_d;
      pv_q        <= pv_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    win_q        <= win_d;
    map_q        <= map_d;
    cnt_q        <= cnt_d;
    round_q      <= round_d;
    pass_q       <= pass_d;
    alg_q        <= alg_d;
    carry_q      <= carry_d;
    paddr_q      <= paddr_d;
    res_data_q   <= res_data_d;
    res_backup_q <= res_backup_d;
  end

  assign result_valid_o = res_valid_q;
  assign data_byte_o    = res_data_q;
  assign backup_word_o  = res_backup_q;

`ifndef NO_ASSERTIONS
  // A result word only leaves once the sequencer is back at rest.
  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy_o)
    else $error("result word while busy");

  // The RAM is never written while the block is at rest.
  a_no_idle_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q != ST_IDLE))
    else $error("RAM write while idle");

  // An accepted command either answers at once or keeps the block busy.
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (busy_o || result_valid_o))
    else $error("accepted command lost");
`endif

endmodule
